FILE: src/assert_macros.svh
// assertion helpers, sampled on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HVT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define HVT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: src/hvt_pkg.sv
`default_nettype none
package hvt_pkg;

	localparam int NumPairs = 8;
	localparam int CoordW   = 32;
	localparam int FracBits = 16;
	localparam int ProdW    = 64;
	localparam int SumW     = 66;
	localparam int MagW     = 64;
	localparam int QuotW    = 32;
	localparam int CfgIdxW  = 4;
	localparam int CfgW     = 64;
	localparam int NumRows  = 4;
	localparam int NumLanes = 3;

	localparam logic [CfgW-1:0] MatReset [NumPairs] = '{
		64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
		64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
	};

	localparam logic [QuotW-1:0] PosMax = 32'h7FFF_FFFF;
	localparam logic [QuotW-1:0] NegMax = 32'h8000_0000;
	localparam logic [MagW-1:0]  WOne   = 64'h0000_0001_0000_0000;

	typedef struct packed {
		logic signed [CoordW-1:0] in_x;
		logic signed [CoordW-1:0] in_y;
		logic signed [CoordW-1:0] in_z;
	} in_t;

	typedef struct packed {
		logic signed [CoordW-1:0] out_x;
		logic signed [CoordW-1:0] out_y;
		logic signed [CoordW-1:0] out_z;
		logic                     w_was_zero;
		logic                     saturated;
	} out_t;

endpackage
`default_nettype wire

FILE: src/homogeneous_vertex_transform.sv
// homogeneous vertex transform: point times 4x4 matrix, then divide by w
// input channel in_valid/in_stall/in_data carries one point (Q16.16 x, y, z)
// output channel out_valid/out_stall/out_data carries the divided point,
// a flag for w being zero (1.0 used) and a flag for any clamped coordinate
// matrix lives in eight 64-bit registers written through cfg_we/cfg_index/
// cfg_data; the user must write them only while the block is idle, which the
// block does not enforce; indexes past seven are ignored; the stages are one
// multiply, one row-sum, one magnitude, one divide setup, 32 restoring
// divide stages (one quotient bit each, three dividers side by side) and the
// output register; with fully pipelined dividers throughput is one beat per
// cycle while the output is not stalled; a stage holds while the next one is
// full and stalled, so an output stall fills the bubbles first and only then
// stalls the input; reset clears all valid bits and loads the identity matrix
`default_nettype none
`include "assert_macros.svh"
module homogeneous_vertex_transform (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [hvt_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [hvt_pkg::CfgW-1:0]       cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire hvt_pkg::in_t                   in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output hvt_pkg::out_t                       out_data
);

	localparam int DivSteps  = hvt_pkg::QuotW;
	localparam int DivBase   = 4;
	localparam int NumStages = DivBase + DivSteps + 1;

	logic [hvt_pkg::CfgW-1:0]         mat_q [hvt_pkg::NumPairs];
	logic signed [hvt_pkg::CoordW-1:0] ent [16];
	logic signed [hvt_pkg::CoordW-1:0] coord [hvt_pkg::NumLanes];

	logic [NumStages:1]   v_s;
	logic [NumStages+1:1] adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hvt_pkg::NumPairs; i++) mat_q[i] <= hvt_pkg::MatReset[i];
		end else if (cfg_we && (cfg_index < hvt_pkg::CfgIdxW'(hvt_pkg::NumPairs))) begin
			mat_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int k = 0; k < 16; k++) ent[k] = mat_q[k/2][(k%2)*32 +: 32];
		coord[0] = in_data.in_x;
		coord[1] = in_data.in_y;
		coord[2] = in_data.in_z;
	end

	// stage advance chain
	always_comb begin
		adv[NumStages+1] = !out_stall;
		for (int k = NumStages; k >= 1; k--) adv[k] = !v_s[k] || adv[k+1];
	end

	assign in_stall  = !adv[1];
	assign out_valid = v_s[NumStages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 1; k <= NumStages; k++) begin
				if (adv[k]) v_s[k] <= (k == 1) ? in_valid : v_s[k-1];
			end
		end
	end

	// stage 1: products
	logic signed [hvt_pkg::ProdW-1:0]  prod_s1 [hvt_pkg::NumRows][hvt_pkg::NumLanes];
	logic signed [hvt_pkg::CoordW-1:0] trans_s1 [hvt_pkg::NumRows];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int r = 0; r < hvt_pkg::NumRows; r++) begin
				for (int c = 0; c < hvt_pkg::NumLanes; c++) begin
					prod_s1[r][c] <= hvt_pkg::ProdW'(ent[4*c+r]) * hvt_pkg::ProdW'(coord[c]);
				end
				trans_s1[r] <= ent[12+r];
			end
		end
	end

	// stage 2: row sums
	logic signed [hvt_pkg::SumW-1:0] sum_s2 [hvt_pkg::NumRows];

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int r = 0; r < hvt_pkg::NumRows; r++) begin
				sum_s2[r] <= hvt_pkg::SumW'(prod_s1[r][0]) + hvt_pkg::SumW'(prod_s1[r][1])
					+ hvt_pkg::SumW'(prod_s1[r][2])
					+ (hvt_pkg::SumW'(trans_s1[r]) <<< hvt_pkg::FracBits);
			end
		end
	end

	// stage 3: sign and magnitude, zero w replaced by 1.0
	logic [hvt_pkg::MagW-1:0] nmag_s3 [hvt_pkg::NumLanes];
	logic [hvt_pkg::NumLanes-1:0] nneg_s3;
	logic [hvt_pkg::MagW-1:0] wmag_s3;
	logic                     wneg_s3;
	logic                     wz_s3;
	logic [hvt_pkg::SumW-1:0] mag_c [hvt_pkg::NumRows];

	always_comb begin
		for (int r = 0; r < hvt_pkg::NumRows; r++) begin
			mag_c[r] = sum_s2[r][hvt_pkg::SumW-1] ? -sum_s2[r] : sum_s2[r];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int c = 0; c < hvt_pkg::NumLanes; c++) begin
				nmag_s3[c] <= mag_c[c][hvt_pkg::MagW-1:0];
				nneg_s3[c] <= sum_s2[c][hvt_pkg::SumW-1];
			end
			if (mag_c[3][hvt_pkg::MagW-1:0] == '0) begin
				wmag_s3 <= hvt_pkg::WOne;
				wneg_s3 <= 1'b0;
				wz_s3   <= 1'b1;
			end else begin
				wmag_s3 <= mag_c[3][hvt_pkg::MagW-1:0];
				wneg_s3 <= sum_s2[3][hvt_pkg::SumW-1];
				wz_s3   <= 1'b0;
			end
		end
	end

	// divide pipeline, entry 0 is the setup stage
	logic [hvt_pkg::MagW-1:0]  div_rem_s [DivSteps+1][hvt_pkg::NumLanes];
	logic [hvt_pkg::QuotW-1:0] div_lo_s  [DivSteps+1][hvt_pkg::NumLanes];
	logic [hvt_pkg::QuotW-1:0] div_q_s   [DivSteps+1][hvt_pkg::NumLanes];
	logic [hvt_pkg::NumLanes-1:0] div_ovf_s [DivSteps+1];
	logic [hvt_pkg::NumLanes-1:0] div_neg_s [DivSteps+1];
	logic [hvt_pkg::MagW-1:0]  div_d_s   [DivSteps+1];
	logic                      div_wz_s  [DivSteps+1];

	always_ff @(posedge clk) begin
		if (adv[DivBase]) begin
			for (int c = 0; c < hvt_pkg::NumLanes; c++) begin
				div_ovf_s[0][c] <= {16'b0, nmag_s3[c]} >= {wmag_s3, 16'b0};
				div_rem_s[0][c] <= {16'b0, nmag_s3[c][hvt_pkg::MagW-1:hvt_pkg::FracBits]};
				div_lo_s[0][c]  <= {nmag_s3[c][hvt_pkg::FracBits-1:0], 16'b0};
				div_q_s[0][c]   <= '0;
				div_neg_s[0][c] <= nneg_s3[c] ^ wneg_s3;
			end
			div_d_s[0]  <= wmag_s3;
			div_wz_s[0] <= wz_s3;
		end
	end

	for (genvar j = 1; j <= DivSteps; j++) begin : g_div
		logic [hvt_pkg::MagW:0] t_c [hvt_pkg::NumLanes];
		logic [hvt_pkg::MagW:0] r_c [hvt_pkg::NumLanes];
		logic [hvt_pkg::NumLanes-1:0] ge_c;

		always_comb begin
			for (int c = 0; c < hvt_pkg::NumLanes; c++) begin
				t_c[c]  = {div_rem_s[j-1][c], div_lo_s[j-1][c][hvt_pkg::QuotW-1]};
				ge_c[c] = t_c[c] >= {1'b0, div_d_s[j-1]};
				r_c[c]  = ge_c[c] ? t_c[c] - {1'b0, div_d_s[j-1]} : t_c[c];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[DivBase+j]) begin
				for (int c = 0; c < hvt_pkg::NumLanes; c++) begin
					div_rem_s[j][c] <= r_c[c][hvt_pkg::MagW-1:0];
					div_lo_s[j][c]  <= {div_lo_s[j-1][c][hvt_pkg::QuotW-2:0], 1'b0};
					div_q_s[j][c]   <= {div_q_s[j-1][c][hvt_pkg::QuotW-2:0], ge_c[c]};
				end
				div_ovf_s[j] <= div_ovf_s[j-1];
				div_neg_s[j] <= div_neg_s[j-1];
				div_d_s[j]   <= div_d_s[j-1];
				div_wz_s[j]  <= div_wz_s[j-1];
			end
		end
	end

	// output stage: sign and clamp
	logic [hvt_pkg::QuotW-1:0]    res_c [hvt_pkg::NumLanes];
	logic [hvt_pkg::NumLanes-1:0] sat_c;
	hvt_pkg::out_t                res_sout;

	always_comb begin
		for (int c = 0; c < hvt_pkg::NumLanes; c++) begin
			if (!div_neg_s[DivSteps][c]) begin
				sat_c[c] = div_ovf_s[DivSteps][c] || (div_q_s[DivSteps][c] > hvt_pkg::PosMax);
				res_c[c] = sat_c[c] ? hvt_pkg::PosMax : div_q_s[DivSteps][c];
			end else begin
				sat_c[c] = div_ovf_s[DivSteps][c] || (div_q_s[DivSteps][c] > hvt_pkg::NegMax);
				res_c[c] = sat_c[c] ? hvt_pkg::NegMax : -div_q_s[DivSteps][c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NumStages]) begin
			res_sout.out_x      <= res_c[0];
			res_sout.out_y      <= res_c[1];
			res_sout.out_z      <= res_c[2];
			res_sout.w_was_zero <= div_wz_s[DivSteps];
			res_sout.saturated  <= |sat_c;
		end
	end

	assign out_data = res_sout;

	`HVT_ASSERT(a_empty_out_no_stall, !out_valid |-> !in_stall, "input stalled with empty output")
	`HVT_ASSERT_NEXT(a_in_beat_lands, in_valid && !in_stall, v_s[1], "input beat lost")
	`HVT_ASSERT(a_sat_means_clamp, out_valid && out_data.saturated |->
		(out_data.out_x == hvt_pkg::PosMax || out_data.out_x == hvt_pkg::NegMax ||
		out_data.out_y == hvt_pkg::PosMax || out_data.out_y == hvt_pkg::NegMax ||
		out_data.out_z == hvt_pkg::PosMax || out_data.out_z == hvt_pkg::NegMax),
		"saturated set without clamped coordinate")

endmodule
`default_nettype wire

FILE: bench/homogeneous_vertex_transform_tb.sv
`default_nettype none
module homogeneous_vertex_transform_tb;

	localparam int Latency   = 37;
	localparam int WatchLim  = 4000;
	localparam int PerMatrix = 35;

	typedef enum logic [1:0] {ROW_CFG, ROW_PT, ROW_PT_TYPED} row_kind_e;
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	typedef struct {
		row_kind_e                   kind;
		logic [hvt_pkg::CfgIdxW-1:0] idx;
		logic [hvt_pkg::CfgW-1:0]    data;
		hvt_pkg::in_t                pt;
		hvt_pkg::out_t               want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [hvt_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [hvt_pkg::CfgW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	hvt_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	hvt_pkg::out_t out_data;

	logic [hvt_pkg::CfgW-1:0] mat_shadow [hvt_pkg::NumPairs];
	hvt_pkg::out_t expected_pts [$];
	stim_row_t dir_rows [$];
	idle_mode_e idle_mode = IDLE_NONE;
	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	int cfg_writes = 0;
	int wzero_seen = 0;
	int sat_seen = 0;
	int idle_cycles = 0;

	homogeneous_vertex_transform dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #4 clk = ~clk;

	function automatic logic signed [67:0] mat_entry(int k);
		logic signed [31:0] e;
		e = k[0] ? mat_shadow[k >> 1][63:32] : mat_shadow[k >> 1][31:0];
		return 68'(e);
	endfunction

	function automatic logic signed [67:0] row_total(int r, hvt_pkg::in_t p);
		logic signed [67:0] xs, ys, zs, acc;
		xs = 68'(p.in_x);
		ys = 68'(p.in_y);
		zs = 68'(p.in_z);
		acc = mat_entry(r) * xs + mat_entry(4 + r) * ys + mat_entry(8 + r) * zs
			+ mat_entry(12 + r) * 68'sd65536;
		return acc;
	endfunction

	function automatic logic [31:0] div_sat(logic nneg, logic [63:0] nmag, logic dneg,
			logic [63:0] dmag, ref logic sat);
		logic [79:0] q;
		q = {nmag, 16'h0} / {16'h0, dmag};
		if (nneg == dneg) begin
			if (q > 80'h7FFF_FFFF) begin
				sat = 1'b1;
				q = 80'h7FFF_FFFF;
			end
			return q[31:0];
		end
		if (q > 80'h8000_0000) begin
			sat = 1'b1;
			q = 80'h8000_0000;
		end
		return 32'h0 - q[31:0];
	endfunction

	function automatic hvt_pkg::out_t project_point(hvt_pkg::in_t p);
		logic signed [67:0] acc;
		logic [67:0] mag;
		logic wneg, nneg, sat;
		logic [63:0] wmag;
		logic [31:0] q [3];
		hvt_pkg::out_t o;
		sat = 1'b0;
		acc = row_total(3, p);
		wneg = acc[67];
		mag = wneg ? -acc : acc;
		wmag = mag[63:0];
		o.w_was_zero = (wmag == 0);
		if (o.w_was_zero) begin
			wmag = hvt_pkg::WOne;
			wneg = 1'b0;
		end
		for (int r = 0; r < 3; r++) begin
			acc = row_total(r, p);
			nneg = acc[67];
			mag = nneg ? -acc : acc;
			q[r] = div_sat(nneg, mag[63:0], wneg, wmag, sat);
		end
		o.out_x = q[0];
		o.out_y = q[1];
		o.out_z = q[2];
		o.saturated = sat;
		return o;
	endfunction

	function automatic hvt_pkg::in_t mk_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		hvt_pkg::in_t p;
		p.in_x = x;
		p.in_y = y;
		p.in_z = z;
		return p;
	endfunction

	function automatic hvt_pkg::out_t mk_out(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic wz, logic sat);
		hvt_pkg::out_t o;
		o.out_x = x;
		o.out_y = y;
		o.out_z = z;
		o.w_was_zero = wz;
		o.saturated = sat;
		return o;
	endfunction

	function automatic void add_cfg(int idx, logic [63:0] data);
		stim_row_t r;
		r.kind = ROW_CFG;
		r.idx = hvt_pkg::CfgIdxW'(idx);
		r.data = data;
		r.pt = '0;
		r.want = '0;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_pt(hvt_pkg::in_t p);
		stim_row_t r;
		r.kind = ROW_PT;
		r.idx = '0;
		r.data = '0;
		r.pt = p;
		r.want = '0;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_typed(hvt_pkg::in_t p, hvt_pkg::out_t o);
		stim_row_t r;
		r.kind = ROW_PT_TYPED;
		r.idx = '0;
		r.data = '0;
		r.pt = p;
		r.want = o;
		dir_rows.push_back(r);
	endfunction

	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
			2: begin
				case ($urandom_range(3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: v = {{13{1'b0}}, 19'($urandom)} - 32'h0004_0000;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_entry(int style, int k);
		logic [31:0] v;
		case (style)
			0: v = {{13{1'b0}}, 19'($urandom)} - 32'h0004_0000;
			1: v = $urandom;
			2: begin
				case ($urandom_range(3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0001_0000;
					default: v = 32'h0;
				endcase
			end
			default: begin
				if (k == 15)
					v = ($urandom_range(3) == 0) ? 32'h0 : 32'h0001_0000;
				else if (k == 3 || k == 7 || k == 11)
					v = ($urandom_range(1) == 0) ? 32'h0 : 32'($urandom_range(255)) - 32'd128;
				else
					v = {{13{1'b0}}, 19'($urandom)} - 32'h0004_0000;
			end
		endcase
		return v;
	endfunction

	task automatic write_reg(logic [hvt_pkg::CfgIdxW-1:0] idx, logic [hvt_pkg::CfgW-1:0] data);
		while (expected_pts.size() != 0)
			@(negedge clk);
		repeat (Latency + 3) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		if (idx < hvt_pkg::NumPairs)
			mat_shadow[idx[2:0]] = data;
		cfg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_point(hvt_pkg::in_t p, hvt_pkg::out_t want);
		while ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) && $urandom_range(99) < 74) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_pts.push_back(want);
		beats_in++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
			out_stall = ($urandom_range(99) < 74);
		else
			out_stall = 1'b0;
	end

	always @(posedge clk) begin
		hvt_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (out_data.w_was_zero)
				wzero_seen++;
			if (out_data.saturated)
				sat_seen++;
			if (expected_pts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %h", out_data);
			end else begin
				want = expected_pts.pop_front();
				if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
						out_data.out_z !== want.out_z ||
						out_data.w_was_zero !== want.w_was_zero ||
						out_data.saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%h y=%h z=%h wz=%b sat=%b, got x=%h y=%h z=%h wz=%b sat=%b",
							want.out_x, want.out_y, want.out_z, want.w_was_zero, want.saturated,
							out_data.out_x, out_data.out_y, out_data.out_z,
							out_data.w_was_zero, out_data.saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchLim) begin
				$display("[homogeneous_vertex_transform] ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] ent [16];
		for (int i = 0; i < hvt_pkg::NumPairs; i++)
			mat_shadow[i] = hvt_pkg::MatReset[i];
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity after reset
		add_typed(mk_pt(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000),
			mk_out(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 1'b0, 1'b0));
		add_typed(mk_pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h0),
			mk_out(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0));
		add_typed(mk_pt(32'h0, 32'h0, 32'h0), mk_out(32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
		// write past the last register is dropped
		add_cfg(9, 64'hFFFF_FFFF_FFFF_FFFF);
		add_cfg(15, 64'h0);
		add_typed(mk_pt(32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001),
			mk_out(32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0));
		// zero w falls back to one
		add_cfg(7, 64'h0);
		add_typed(mk_pt(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF),
			mk_out(32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0));
		// tiny w drives clamping both ways
		add_cfg(7, 64'h0000_0001_0000_0000);
		add_typed(mk_pt(32'h0002_0000, 32'hFFFE_0000, 32'h0),
			mk_out(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, 1'b1));
		add_typed(mk_pt(32'h0, 32'h0, 32'h0000_0001),
			mk_out(32'h0, 32'h0, 32'h0001_0000, 1'b0, 1'b0));
		// negative w flips signs, zero stays zero
		add_cfg(7, 64'hFFFF_0000_0000_0000);
		add_typed(mk_pt(32'h0001_0000, 32'hFFFF_0000, 32'h0),
			mk_out(32'hFFFF_0000, 32'h0001_0000, 32'h0, 1'b0, 1'b0));
		// huge negative w truncates small quotients to zero
		add_cfg(7, 64'h8000_0000_0000_0000);
		add_typed(mk_pt(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000),
			mk_out(32'h0, 32'h0, 32'hFFFF_FFFE, 1'b0, 1'b0));
		add_cfg(0, 64'h8000_0000_7FFF_FFFF);
		add_cfg(1, 64'h7FFF_FFFF_8000_0000);
		add_cfg(2, 64'h8000_0000_8000_0000);
		add_cfg(3, 64'h7FFF_FFFF_0003_0000);
		add_cfg(4, 64'h7FFF_FFFF_7FFF_FFFF);
		add_cfg(5, 64'h8000_0000_FFFF_FFFF);
		add_cfg(6, 64'h0000_0000_8000_0000);
		add_cfg(7, 64'h0001_0000_7FFF_FFFF);
		add_pt(mk_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		add_pt(mk_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		add_pt(mk_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
		add_pt(mk_pt(32'h0000_0001, 32'hFFFF_FFFF, 32'h0));

		@(negedge clk);
		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG: write_reg(dir_rows[i].idx, dir_rows[i].data);
				ROW_PT: send_point(dir_rows[i].pt, project_point(dir_rows[i].pt));
				default: send_point(dir_rows[i].pt, dir_rows[i].want);
			endcase
		end

		for (int ph = 0; ph < 4; ph++) begin
			for (int m = 0; m < 4; m++) begin
				idle_mode = IDLE_NONE;
				for (int k = 0; k < 16; k++)
					ent[k] = rand_entry((ph + m) % 4, k);
				for (int i = 0; i < hvt_pkg::NumPairs; i++)
					write_reg(hvt_pkg::CfgIdxW'(i), {ent[2 * i + 1], ent[2 * i]});
				idle_mode = idle_mode_e'(ph);
				for (int n = 0; n < PerMatrix; n++) begin
					hvt_pkg::in_t p;
					p = mk_pt(rand_coord(), rand_coord(), rand_coord());
					send_point(p, project_point(p));
				end
			end
		end

		while (expected_pts.size() != 0)
			@(negedge clk);
		repeat (Latency + 3) @(negedge clk);
		$display("covered %0d points in, %0d beats out, %0d register writes over four idle modes",
			beats_in, beats_out, cfg_writes);
		$display("zero-w results %0d, clamped results %0d, mismatches %0d",
			wzero_seen, sat_seen, mismatches);
		if (mismatches == 0 && expected_pts.size() == 0)
			$display("[homogeneous_vertex_transform] OK");
		else
			$display("[homogeneous_vertex_transform] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
